// ===== sv/spba_pkg.sv =====
// package for the segregated pool block allocator
// holds pool geometry tables, status and mode codes, controller/datapath structs
package spba_pkg;

  localparam int POOLS_DEF      = 6;
  localparam int MAX_BLOCKS_DEF = 2048;
  localparam int POOL_SLOTS     = 8;

  localparam logic [20:0] USAGE_MAX = 21'h1FFFFF;

  localparam logic [12:0] SMALL_LIMIT_RST  = 13'd64;
  localparam logic [12:0] MEDIUM_LIMIT_RST = 13'd512;

  typedef enum logic [1:0] {
    MODE_ALLOC_SIZE = 2'd0,
    MODE_ALLOC_POOL = 2'd1,
    MODE_FREE       = 2'd2,
    MODE_RESET_POOL = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_ZERO_SIZE = 3'd2,
    ST_BAD_POOL  = 3'd3,
    ST_DOUBLE    = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_t;

  localparam logic [0:0] CFG_SMALL  = 1'b0;
  localparam logic [0:0] CFG_MEDIUM = 1'b1;

  function automatic logic [12:0] pool_bytes(input logic [2:0] p);
    logic [12:0] b;
    unique case (p)
      3'd0:    b = 13'd64;
      3'd1:    b = 13'd512;
      3'd2:    b = 13'd4096;
      3'd3:    b = 13'd128;
      3'd4:    b = 13'd256;
      default: b = 13'd64;
    endcase
    return b;
  endfunction

  function automatic logic [12:0] pool_blocks(input logic [2:0] p);
    logic [12:0] n;
    unique case (p)
      3'd0:    n = 13'd1024;
      3'd1:    n = 13'd512;
      3'd2:    n = 13'd128;
      3'd3:    n = 13'd2048;
      3'd4:    n = 13'd1024;
      default: n = 13'd2048;
    endcase
    return n;
  endfunction

  // controller -> datapath commands
  typedef struct packed {
    logic latch;     // capture request and decode
    logic mem_rd;    // issue link / flag memory reads
    logic commit;    // update state and drive result
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_mem;  // request needs the memory read cycle
  } dp_sts_t;

endpackage

// ===== sv/segregated_pool_block_allocator.sv =====
// top level of the segregated pool block allocator
// sequence: S_IDLE latches the request on start, S_READ reads the link and flag stores,
// S_COMMIT updates state and the result; start is ignored while busy (outside S_IDLE)
// reset: rst_n synchronous active low clears heads, watermarks, counters, reloads limits
// link and in-use stores are not cleared; the receiver cannot stall the result
module segregated_pool_block_allocator #(
  parameter int POOLS      = spba_pkg::POOLS_DEF,
  parameter int MAX_BLOCKS = spba_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic [1:0]  in_mode,
  input  logic [23:0] in_request_size,
  input  logic [2:0]  in_pool_select,
  input  logic [10:0] in_block_index,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [2:0]  out_pool_out,
  output logic [10:0] out_handle_index,
  output logic [12:0] out_block_bytes,
  output logic [11:0] out_pool_used,
  output logic [20:0] out_usage_bytes,
  output logic [20:0] out_peak_bytes,
  output logic [31:0] out_allocations_done,
  output logic [31:0] out_frees_done
);

  // command and status between controller and datapath
  spba_pkg::dp_cmd_t cmd;
  spba_pkg::dp_sts_t sts;

  spba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  spba_dp #(
    .POOLS      (POOLS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_mode              (in_mode),
    .in_request_size      (in_request_size),
    .in_pool_select       (in_pool_select),
    .in_block_index       (in_block_index),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_pool_out         (out_pool_out),
    .out_handle_index     (out_handle_index),
    .out_block_bytes      (out_block_bytes),
    .out_pool_used        (out_pool_used),
    .out_usage_bytes      (out_usage_bytes),
    .out_peak_bytes       (out_peak_bytes),
    .out_allocations_done (out_allocations_done),
    .out_frees_done       (out_frees_done)
  );

endmodule

// ===== sv/spba_ctrl.sv =====
// controller state machine for the pool allocator
// depends on spba_pkg
module spba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spba_pkg::dp_sts_t sts,
  output spba_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_READ   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.latch  = 1'b0;
    cmd.mem_rd = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_rd = sts.need_mem;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/spba_dp.sv =====
// datapath of the pool allocator: list heads, watermarks, link and flag memories, counters
// depends on spba_pkg
module spba_dp #(
  parameter int POOLS      = spba_pkg::POOLS_DEF,
  parameter int MAX_BLOCKS = spba_pkg::MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spba_pkg::dp_cmd_t cmd,
  output spba_pkg::dp_sts_t sts,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [12:0]       cfg_wdata,
  input  logic [1:0]        in_mode,
  input  logic [23:0]       in_request_size,
  input  logic [2:0]        in_pool_select,
  input  logic [10:0]       in_block_index,
  output logic              out_valid,
  output logic [2:0]        out_status,
  output logic [2:0]        out_pool_out,
  output logic [10:0]       out_handle_index,
  output logic [12:0]       out_block_bytes,
  output logic [11:0]       out_pool_used,
  output logic [20:0]       out_usage_bytes,
  output logic [20:0]       out_peak_bytes,
  output logic [31:0]       out_allocations_done,
  output logic [31:0]       out_frees_done
);

  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int CW    = IW + 1;
  localparam int PW    = $clog2(POOLS);
  localparam int DEPTH = POOLS * MAX_BLOCKS;
  localparam int AW    = PW + IW;
  localparam logic [20:0] USAGE_MAX_L = spba_pkg::USAGE_MAX;

  logic [12:0] small_lim_r, medium_lim_r;

  logic [IW-1:0] head_r    [POOLS];
  logic [CW-1:0] rcount_r  [POOLS];
  logic [CW-1:0] water_r   [POOLS];
  logic [CW-1:0] used_r    [POOLS];
  logic [31:0]   ppalloc_r [POOLS];

  logic [IW-1:0] link_mem [DEPTH];
  logic          flag_mem [DEPTH];
  logic [IW-1:0] link_rd_r;
  logic          flag_rd_r;

  logic [20:0] cur_r, peak_r;
  logic [47:0] atot_r, ftot_r;
  logic [31:0] acnt_r, fcnt_r;

  // latched request
  logic [1:0]  mode_r;
  logic        zero_r, badp_r;
  logic [2:0]  pool_r;
  logic [PW-1:0] pidx_r;
  logic [IW-1:0] idx_r;
  logic        idx_ok_r;

  // decode
  logic [2:0] sel_pool;
  logic       is_size;
  always_comb begin
    is_size = (in_mode == spba_pkg::MODE_ALLOC_SIZE);
    if (!is_size) sel_pool = in_pool_select;
    else if (in_request_size <= {11'd0, small_lim_r}) sel_pool = 3'd0;
    else if (in_request_size <= {11'd0, medium_lim_r}) sel_pool = 3'd1;
    else sel_pool = 3'd2;
  end

  logic [12:0] cnt_in, cnt_lat;
  always_comb begin
    cnt_in = spba_pkg::pool_blocks(sel_pool);
    if (cnt_in > 13'(MAX_BLOCKS)) cnt_in = 13'(MAX_BLOCKS);
    cnt_lat = spba_pkg::pool_blocks(pool_r);
    if (cnt_lat > 13'(MAX_BLOCKS)) cnt_lat = 13'(MAX_BLOCKS);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r   <= in_mode;
      zero_r   <= is_size && (in_request_size == 24'd0);
      badp_r   <= !is_size && ({1'b0, in_pool_select} >= 4'(POOLS));
      pool_r   <= sel_pool;
      pidx_r   <= PW'(sel_pool);
      idx_r    <= IW'(in_block_index);
      idx_ok_r <= ({2'b0, in_block_index} < cnt_in);
    end
  end

  logic valid_op;
  assign valid_op = !zero_r && !badp_r;
  logic [AW-1:0] rd_addr;
  assign rd_addr = AW'(pidx_r * MAX_BLOCKS) +
                   ((mode_r == spba_pkg::MODE_FREE) ? AW'(idx_r) : AW'(head_r[pidx_r]));
  assign sts.need_mem = valid_op;

  // commit
  logic [12:0] bytes;
  logic        is_alloc, use_rec, use_fresh, do_alloc, do_free, do_rst;
  logic [2:0]  st;
  logic [IW-1:0] aidx;
  logic [AW-1:0] wr_addr;
  logic [21:0] cur_add;
  logic [20:0] cur_new;
  logic [CW-1:0] used_new;
  always_comb begin
    bytes     = spba_pkg::pool_bytes(pool_r);
    is_alloc  = (mode_r == spba_pkg::MODE_ALLOC_SIZE) || (mode_r == spba_pkg::MODE_ALLOC_POOL);
    use_rec   = rcount_r[pidx_r] != '0;
    use_fresh = !use_rec && ({{(13-CW){1'b0}}, water_r[pidx_r]} < cnt_lat);
    do_alloc  = 1'b0; do_free = 1'b0; do_rst = 1'b0;
    aidx      = use_rec ? head_r[pidx_r] : IW'(water_r[pidx_r]);
    st        = spba_pkg::ST_OK;
    if (zero_r) st = spba_pkg::ST_ZERO_SIZE;
    else if (badp_r) st = spba_pkg::ST_BAD_POOL;
    else if (is_alloc) begin
      if (use_rec || use_fresh) do_alloc = 1'b1;
      else st = spba_pkg::ST_EXHAUSTED;
    end else if (mode_r == spba_pkg::MODE_FREE) begin
      if (!idx_ok_r) st = spba_pkg::ST_BAD_INDEX;
      else if (({1'b0, idx_r} >= water_r[pidx_r]) || !flag_rd_r) st = spba_pkg::ST_DOUBLE;
      else do_free = 1'b1;
    end else do_rst = 1'b1;
    wr_addr = AW'(pidx_r * MAX_BLOCKS) + AW'(do_free ? idx_r : aidx);
    cur_add = {1'b0, cur_r} + {9'd0, bytes};
    if (do_alloc) cur_new = cur_add[21] ? USAGE_MAX_L : cur_add[20:0];
    else if (do_free && cur_r >= {8'd0, bytes}) cur_new = cur_r - {8'd0, bytes};
    else cur_new = cur_r;
    used_new = used_r[pidx_r];
    if (do_alloc) used_new = used_r[pidx_r] + 1'b1;
    else if (do_free && used_r[pidx_r] != '0) used_new = used_r[pidx_r] - 1'b1;
    else if (do_rst) used_new = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      link_rd_r <= link_mem[rd_addr];
      flag_rd_r <= flag_mem[rd_addr];
    end
    if (cmd.commit && (do_alloc || do_free)) begin
      flag_mem[wr_addr] <= do_alloc;
      if (do_free) link_mem[wr_addr] <= head_r[pidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      small_lim_r  <= spba_pkg::SMALL_LIMIT_RST;
      medium_lim_r <= spba_pkg::MEDIUM_LIMIT_RST;
      for (int i = 0; i < POOLS; i++) begin
        head_r[i] <= '0; rcount_r[i] <= '0; water_r[i] <= '0;
        used_r[i] <= '0; ppalloc_r[i] <= '0;
      end
      cur_r <= '0; peak_r <= '0; atot_r <= '0; ftot_r <= '0;
      acnt_r <= '0; fcnt_r <= '0; out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == spba_pkg::CFG_SMALL) small_lim_r <= cfg_wdata;
        else medium_lim_r <= cfg_wdata;
      end
      out_valid <= cmd.commit;
      if (cmd.commit) begin
        if (do_alloc) begin
          if (use_rec) begin
            head_r[pidx_r]   <= link_rd_r;
            rcount_r[pidx_r] <= rcount_r[pidx_r] - 1'b1;
          end else water_r[pidx_r] <= water_r[pidx_r] + 1'b1;
          atot_r <= atot_r + {35'd0, bytes};
          acnt_r <= acnt_r + 32'd1;
          ppalloc_r[pidx_r] <= ppalloc_r[pidx_r] + 32'd1;
          if (cur_new > peak_r) peak_r <= cur_new;
        end
        if (do_free) begin
          head_r[pidx_r]   <= idx_r;
          rcount_r[pidx_r] <= rcount_r[pidx_r] + 1'b1;
          ftot_r <= ftot_r + {35'd0, bytes};
          fcnt_r <= fcnt_r + 32'd1;
        end
        if (do_rst) begin
          head_r[pidx_r] <= '0; rcount_r[pidx_r] <= '0; water_r[pidx_r] <= '0;
        end
        if (valid_op) used_r[pidx_r] <= used_new;
        cur_r <= cur_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status       <= st;
      out_pool_out     <= zero_r ? 3'd0 : pool_r;
      out_handle_index <= do_alloc ? 11'(aidx) : 11'd0;
      out_block_bytes  <= (do_alloc || do_free) ? bytes : 13'd0;
      out_pool_used    <= valid_op ? 12'(used_new) : 12'd0;
      out_usage_bytes  <= cur_new;
      out_peak_bytes   <= (do_alloc && cur_new > peak_r) ? cur_new : peak_r;
      out_allocations_done <= do_alloc ? acnt_r + 32'd1 : acnt_r;
      out_frees_done   <= do_free ? fcnt_r + 32'd1 : fcnt_r;
    end
  end

endmodule
